>>> rtl/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared types and constants for the RGBA8 linear-to-tiled converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rlt_pkg;

  // Tile geometry (fixed by the GX RGBA8 texture format).
  localparam int TILE_SIZE  = 4;
  localparam int TILE_PIXELS = TILE_SIZE * TILE_SIZE;
  localparam int TILE_PAIRS = 2 * TILE_PIXELS;
  localparam int TILE_BYTES = 4 * TILE_PIXELS;

  // Field widths.
  localparam int PIX_W     = 8;
  localparam int WORD_W    = 4 * PIX_W;
  localparam int OFF_W     = 22;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PAIR_W    = $clog2(TILE_PAIRS);

  localparam int CFG_RESET_DIM = 1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Microprogram step addresses.
  typedef logic [1:0] step_t;
  localparam step_t STEP_WAIT     = 2'd0;
  localparam step_t STEP_PREFETCH = 2'd1;
  localparam step_t STEP_STREAM   = 2'd2;
  localparam step_t STEP_SPARE    = 2'd3;

  // Jump conditions of a control word.
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_TILE,
    COND_LAST
  } cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic  take_in;   // input channel open, pixel written to the line store
    logic  rd_first;  // read the first pixel of the tile
    logic  stream;    // move pairs into the output register when it is free
    cond_t cond;      // jump condition
    step_t target;    // jump target
  } ctrl_word_t;

  // Status flags the datapath returns to the sequencer.
  typedef struct packed {
    logic tile_go;    // accepted pixel completes a tile
    logic slot_last;  // last pair of the tile loaded this cycle
  } seq_flags_t;

endpackage

`default_nettype wire

>>> rtl/rgba8_linear_to_tiled_converter.sv
// ----------------------------------------------------------------------------
// rgba8_linear_to_tiled_converter
// Converts raster-order RGBA8 pixels into 4x4 GX tiles of AR and GB pairs.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-------------------------------------
//  in_     | input     | in_valid / in_stall | in_red, in_green, in_blue, in_alpha
//  out_    | output    | out_valid/out_stall | out_first_byte, out_second_byte,
//          |           |                     | out_byte_offset, out_tile_last
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A pixel that does not finish a tile is taken in the wait step. A pixel that
// finishes a tile is followed by a prefetch step that reads the tile's first
// pixel from the line store and then a stream step in which one pair per cycle
// moves into the output register while the output does not stall; the input
// stays closed from that pixel until the last of the tile's 32 pairs is loaded.
// A stall on the output pauses the stream; the output register keeps its
// transaction and the prefetched pixel waits in the store's read register.
// Reset restores 1024 x 1024 (clamped to the maxima) and starts a new image.
// The line store is not cleared: every pixel of a tile is written before it is read.
//
// The control is a three-step microprogram: wait for a pixel, prefetch the
// first tile pixel, stream the 32 pairs. The datapath below follows the
// control word that the sequencer reads from its control store.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba8_linear_to_tiled_converter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Pixel input.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rlt_pkg::PIX_W-1:0]     in_red,
  input  wire logic [rlt_pkg::PIX_W-1:0]     in_green,
  input  wire logic [rlt_pkg::PIX_W-1:0]     in_blue,
  input  wire logic [rlt_pkg::PIX_W-1:0]     in_alpha,
  // Tiled output.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [rlt_pkg::PIX_W-1:0]     out_first_byte,
  output logic      [rlt_pkg::PIX_W-1:0]     out_second_byte,
  output logic      [rlt_pkg::OFF_W-1:0]     out_byte_offset,
  output logic                               out_tile_last,
  // Configuration writes.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rlt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rlt_pkg::CFG_W-1:0]     cfg_data
);
  import rlt_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);       // column position
  localparam int RW    = $clog2(MAX_HEIGHT);      // row position
  localparam int WW    = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int HW    = $clog2(MAX_HEIGHT + 1);  // effective height
  localparam int DEPTH = TILE_SIZE * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int RESET_W = (CFG_RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET_DIM;
  localparam int RESET_H = (CFG_RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET_DIM;

  // Register values are clamped on write: zero acts as one, oversize as the maximum.
  function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
    if (v == '0) return WW'(1);
    if (int'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
    if (v == '0) return HW'(1);
    if (int'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
    return HW'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  ctrl_word_t ctrl;
  step_t      step;
  seq_flags_t flags;

  rlt_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .step  (step),
    .ctrl  (ctrl)
  );

  // ---------------------------------------------------------------------------
  // Image position and configuration
  // ---------------------------------------------------------------------------
  logic [WW-1:0]     eff_w_r;
  logic [HW-1:0]     eff_h_r;
  logic [CW-1:0]     col_r;
  logic [RW-1:0]     row_r;
  logic [OFF_W-1:0]  offset_r;
  logic [OFF_W-1:0]  tile_base_r;
  logic [CW-3:0]     tile_x_r;   // tile column (position / 4)
  logic [RW-3:0]     tile_y_r;   // tile row (position / 4)
  logic [PAIR_W-1:0] pair_r;     // next pair to load into the output register

  logic in_acc;
  logic cfg_acc;
  logic col_last;
  logic row_last;
  logic col_end;
  logic row_end;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = !ctrl.take_in;
  assign in_acc    = in_valid && !in_stall;

  assign col_last = (WW'(col_r) + WW'(1)) >= eff_w_r;
  assign row_last = (HW'(row_r) + HW'(1)) >= eff_h_r;
  assign col_end  = (col_r[1:0] == 2'(TILE_SIZE - 1)) || col_last;
  assign row_end  = (row_r[1:0] == 2'(TILE_SIZE - 1)) || row_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r  <= WW'(RESET_W);
      eff_h_r  <= HW'(RESET_H);
      col_r    <= '0;
      row_r    <= '0;
      offset_r <= '0;
    end else if (cfg_acc) begin
      // Any write to a known register restarts the image.
      if (cfg_index == REG_IMAGE_WIDTH) begin
        eff_w_r  <= clamp_w(cfg_data);
        col_r    <= '0;
        row_r    <= '0;
        offset_r <= '0;
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        eff_h_r  <= clamp_h(cfg_data);
        col_r    <= '0;
        row_r    <= '0;
        offset_r <= '0;
      end
    end else if (in_acc) begin
      if (flags.tile_go) begin
        offset_r <= offset_r + OFF_W'(TILE_BYTES);
      end
      if (col_last) begin
        col_r <= '0;
        if (row_last) begin
          // End of image: the next pixel starts a fresh image at offset zero.
          row_r    <= '0;
          offset_r <= '0;
        end else begin
          row_r <= row_r + RW'(1);
        end
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Tile context latched when a tile completes; it stays put while the pairs
  // stream, since no pixel is taken until the last pair has been loaded.
  always_ff @(posedge clk) begin
    if (flags.tile_go) begin
      tile_base_r <= offset_r;
      tile_x_r    <= col_r[CW-1:2];
      tile_y_r    <= row_r[RW-1:2];
    end
  end

  // ---------------------------------------------------------------------------
  // Line store
  // ---------------------------------------------------------------------------
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [PAIR_W-1:0] rd_pair;
  logic [CW-1:0]     rd_x;
  logic [RW-1:0]     rd_y;
  logic              rd_inside;
  logic              rd_inside_r;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              slot_free;
  logic              load_out;

  assign wr_addr = AW'(row_r[1:0]) * AW'(MAX_WIDTH) + AW'(col_r);
  assign wr_data = {in_alpha, in_blue, in_green, in_red};

  // The output register is free when it is empty or its transaction leaves now.
  assign slot_free = !out_valid || !out_stall;
  assign load_out  = ctrl.stream && slot_free;

  // An accepted pixel that closes a tile starts the stream; the last pair
  // loaded ends it.
  assign flags = '{tile_go:   in_acc && col_end && row_end,
                   slot_last: load_out && (pair_r == PAIR_W'(TILE_PAIRS - 1))};

  // Prefetch reads the pair about to be loaded next. Both halves of a tile
  // walk the same 16 pixels, so bits [3:0] of the pair index pick the pixel.
  assign rd_pair   = ctrl.rd_first ? pair_r : pair_r + PAIR_W'(1);
  assign rd_x      = {tile_x_r, rd_pair[1:0]};
  assign rd_y      = {tile_y_r, rd_pair[3:2]};
  assign rd_inside = (WW'(rd_x) < eff_w_r) && (HW'(rd_y) < eff_h_r);
  assign rd_en     = ctrl.rd_first || load_out;
  assign rd_addr   = rd_inside ? AW'(rd_pair[3:2]) * AW'(MAX_WIDTH) + AW'(rd_x) : '0;

  rlt_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_inside_r <= rd_inside;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r <= '0;
    end else if (flags.tile_go) begin
      pair_r <= '0;
    end else if (load_out) begin
      pair_r <= pair_r + PAIR_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_first_r;
  logic [PIX_W-1:0]  out_second_r;
  logic [OFF_W-1:0]  out_offset_r;
  logic              out_last_r;
  logic [WORD_W-1:0] pix;

  // Pixels outside the image in an edge tile come out as zero.
  assign pix = rd_inside_r ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (!pair_r[PAIR_W-1]) begin
        // Alpha/red half.
        out_first_r  <= pix[31:24];
        out_second_r <= pix[7:0];
      end else begin
        // Green/blue half.
        out_first_r  <= pix[15:8];
        out_second_r <= pix[23:16];
      end
      out_offset_r <= tile_base_r + {(OFF_W - PAIR_W - 1)'(0), pair_r, 1'b0};
      out_last_r   <= (pair_r == PAIR_W'(TILE_PAIRS - 1));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_first_byte  = out_first_r;
  assign out_second_byte = out_second_r;
  assign out_byte_offset = out_offset_r;
  assign out_tile_last   = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pos_in_image : assert property (@(posedge clk) disable iff (!rst_n)
    (WW'(col_r) < eff_w_r) && (HW'(row_r) < eff_h_r))
    else $error("raster position outside the configured image");

  a_load_in_stream : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step == STEP_STREAM))
    else $error("output transaction loaded outside the stream step");

  a_prefetch_first : assert property (@(posedge clk) disable iff (!rst_n)
    (step == STEP_PREFETCH) |-> (pair_r == '0))
    else $error("tile prefetch does not start at the first pair");

  a_last_to_wait : assert property (@(posedge clk) disable iff (!rst_n)
    flags.slot_last |=> (step == STEP_WAIT) && out_valid_r && out_tile_last)
    else $error("sequencer did not return to wait after the last pair");

endmodule

`default_nettype wire

>>> rtl/rlt_line_store.sv
// ----------------------------------------------------------------------------
// rlt_line_store
// Four-row pixel store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_line_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [rlt_pkg::WORD_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [rlt_pkg::WORD_W-1:0] rd_data
);
  import rlt_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/rlt_sequencer.sv
// ----------------------------------------------------------------------------
// rlt_sequencer
// Step counter and control store of the converter's microprogram.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_sequencer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rlt_pkg::seq_flags_t flags,
  output rlt_pkg::step_t           step,
  output rlt_pkg::ctrl_word_t      ctrl
);
  import rlt_pkg::*;

  step_t step_r;
  step_t step_nxt;

  // Control store. The spare address falls back to the wait step.
  function automatic ctrl_word_t ucode(input step_t addr);
    ctrl_word_t w;
    w = '{take_in: 1'b0, rd_first: 1'b0, stream: 1'b0,
          cond: COND_ALWAYS, target: STEP_WAIT};
    unique case (addr)
      STEP_WAIT: begin
        w.take_in = 1'b1;
        w.cond    = COND_TILE;
        w.target  = STEP_PREFETCH;
      end
      STEP_PREFETCH: begin
        w.rd_first = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = STEP_STREAM;
      end
      STEP_STREAM: begin
        w.stream = 1'b1;
        w.cond   = COND_LAST;
        w.target = STEP_WAIT;
      end
      STEP_SPARE: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
      default: begin
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    ctrl     = ucode(step_r);
    step_nxt = step_r;
    unique case (ctrl.cond)
      COND_ALWAYS: step_nxt = ctrl.target;
      COND_TILE:   step_nxt = flags.tile_go ? ctrl.target : step_r;
      COND_LAST:   step_nxt = flags.slot_last ? ctrl.target : step_r;
      default:     step_nxt = STEP_WAIT;
    endcase
  end

  assign step = step_r;

endmodule

`default_nettype wire
